>>> rtl/core/glove_sensor_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glove frame parser
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef GLOVE_SENSOR_FRAME_PARSER_ASSERT_SVH
`define GLOVE_SENSOR_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define GSFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("gsfp assertion failed");

// next-cycle implication
`define GSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gsfp assertion failed");

`endif

>>> rtl/core/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// gsfp_pkg
// Character codes, field numbers, token phases and helpers of the glove
// frame parser.
// ----------------------------------------------------------------------------
package gsfp_pkg;

	localparam int LINE_KEEP_DEF   = 39;
	localparam int FRAC_DIGITS_DEF = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	localparam logic [3:0] FLD_SYNC     = 4'd0;
	localparam logic [3:0] FLD_HAND     = 4'd1;
	localparam logic [3:0] FLD_FINGER_A = 4'd2;
	localparam logic [3:0] FLD_PRESS_A  = 4'd3;
	localparam logic [3:0] FLD_FINGER_B = 4'd4;
	localparam logic [3:0] FLD_PRESS_B  = 4'd5;
	localparam logic [3:0] FLD_RATE_X   = 4'd6;
	localparam logic [3:0] FLD_RATE_Y   = 4'd7;
	localparam logic [3:0] FLD_RATE_Z   = 4'd8;
	localparam logic [3:0] FLD_MAX      = 4'd15;

	localparam logic [2:0] GEST_NOTHING    = 3'd0;
	localparam logic [2:0] GEST_ZOOM       = 3'd1;
	localparam logic [2:0] GEST_PICK       = 3'd2;
	localparam logic [2:0] GEST_SPIN       = 3'd3;
	localparam logic [2:0] GEST_UNDETECTED = 3'd4;

	localparam logic [31:0] MAG_CAP      = 32'h8000_0000;
	localparam logic [41:0] RATE_MAX     = 42'h7F_FFFF;
	localparam logic [41:0] RATE_MIN_MAG = 42'h80_0000;

	typedef enum logic [4:0] {
		PH_WS   = 5'b00001,
		PH_SIGN = 5'b00010,
		PH_INT  = 5'b00100,
		PH_FRAC = 5'b01000,
		PH_DONE = 5'b10000
	} gsfp_phase_t;

	typedef struct packed {
		logic        left_index;
		logic        left_middle;
		logic        right_index;
		logic        right_middle;
		logic [23:0] rate_x;
		logic [23:0] rate_y;
		logic [23:0] rate_z;
		logic [2:0]  gesture_mode;
		logic        frame_complete;
		logic        resync_seen;
	} gsfp_result_t;

	// scale for missing fraction digits
	function automatic logic [9:0] gsfp_pow10(input logic [1:0] n);
		logic [9:0] r;
		case (n)
			2'd0:    r = 10'd1;
			2'd1:    r = 10'd10;
			2'd2:    r = 10'd100;
			default: r = 10'd1000;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] gsfp_gesture(input logic [3:0] p);
		logic [2:0] g;
		case (p) inside
			4'h0:       g = GEST_NOTHING;
			4'h2, 4'h8: g = GEST_ZOOM;
			4'h1, 4'h4: g = GEST_PICK;
			4'h3, 4'hC: g = GEST_SPIN;
			default:    g = GEST_UNDETECTED;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/core/glove_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// glove_sensor_frame_parser: one byte per cycle unless the skid stage is full, state updated at acceptance.
// A newline's report is registered in the output register, or in the skid stage while the output is held.
// Throughput one byte per cycle while in_ready is high; the token update path is combinational.
// Reset clears sync, field and token state, finger bits and gyro values.
// ----------------------------------------------------------------------------
module glove_sensor_frame_parser #(
	parameter int LINE_KEEP       = gsfp_pkg::LINE_KEEP_DEF,
	parameter int FRACTION_DIGITS = gsfp_pkg::FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               left_index,
	output logic               left_middle,
	output logic               right_index,
	output logic               right_middle,
	output logic signed [23:0] rate_x,
	output logic signed [23:0] rate_y,
	output logic signed [23:0] rate_z,
	output logic [2:0]         gesture_mode,
	output logic               frame_complete,
	output logic               resync_seen
);
	import gsfp_pkg::*;

	`include "glove_sensor_frame_parser_assert.svh"

	localparam logic [5:0] KEEP_LEN = 6'(LINE_KEEP);
	localparam logic [1:0] FD_MAX   = 2'(FRACTION_DIGITS);

	// line and token state
	logic [3:0]  field_cnt_q, field_cnt_d;
	logic [5:0]  line_len_q, line_len_d;
	logic        in_token_q, in_token_d;
	logic        synced_q, synced_d;
	logic [31:0] tok_mag_q, tok_mag_d;
	logic        tok_neg_q, tok_neg_d;
	gsfp_phase_t phase_q, phase_d;
	logic [1:0]  frac_cnt_q, frac_cnt_d;
	logic [1:0]  tok_len_q, tok_len_d;
	logic        first_hash_q, first_hash_d;
	logic        hand_ok_q, hand_ok_d, hand_bit_q, hand_bit_d;
	logic        fing_ok_q, fing_ok_d, fing_bit_q, fing_bit_d;
	logic [3:0]  finger_q, finger_d;
	logic [23:0] rate_q [3];
	logic [23:0] rate_d [3];
	logic        flag_frame_q, flag_frame_d;
	logic        flag_resync_q, flag_resync_d;

	// output register and skid stage
	gsfp_result_t out_q, skid_q, res;
	logic         out_valid_q, skid_valid_q;

	logic        acc, res_fire;
	logic        is_nul, is_nl, is_semi, keep;
	logic        do_finish, do_char;
	logic        is_dig, is_ws, is_sign, is_dot, is_gyro;
	logic        int_ok, int_bit;
	logic [41:0] rate_prod;
	logic [23:0] rate_val;
	logic [35:0] mag_ext;

	assign in_ready = !skid_valid_q;
	assign acc      = in_valid && in_ready;
	assign is_nul   = (rx_byte == CH_NUL);
	assign is_nl    = (rx_byte == CH_NL);
	assign is_semi  = (rx_byte == CH_SEMI);
	assign keep     = (line_len_q < KEEP_LEN);
	assign res_fire = acc && is_nl;

	assign do_finish = acc && in_token_q && (is_nl || (keep && is_semi && !is_nul));
	assign do_char   = acc && !is_nul && !is_nl && !is_semi && keep;

	assign is_dig  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_ws   = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
	assign is_sign = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
	assign is_gyro = (field_cnt_q >= FLD_RATE_X) && (field_cnt_q <= FLD_RATE_Z);
	assign is_dot  = (rx_byte == CH_DOT) && is_gyro;

	// integer token reduced to "is it 0 or 1" and its low bit
	assign int_ok  = (tok_mag_q[31:1] == 31'd0) && !(tok_neg_q && tok_mag_q[0]);
	assign int_bit = tok_mag_q[0] && !tok_neg_q;

	assign mag_ext = ({4'd0, tok_mag_q} << 3) + ({4'd0, tok_mag_q} << 1)
		+ {32'd0, rx_byte[3:0]};

	assign rate_prod = {10'd0, tok_mag_q} * {32'd0, gsfp_pow10(FD_MAX - frac_cnt_q)};

	always_comb begin
		if (tok_neg_q) begin
			rate_val = (rate_prod > RATE_MIN_MAG) ? RATE_MIN_MAG[23:0]
				: 24'd0 - rate_prod[23:0];
		end else begin
			rate_val = (rate_prod > RATE_MAX) ? RATE_MAX[23:0] : rate_prod[23:0];
		end
	end

	always_comb begin
		field_cnt_d   = field_cnt_q;
		line_len_d    = line_len_q;
		in_token_d    = in_token_q;
		synced_d      = synced_q;
		tok_mag_d     = tok_mag_q;
		tok_neg_d     = tok_neg_q;
		phase_d       = phase_q;
		frac_cnt_d    = frac_cnt_q;
		tok_len_d     = tok_len_q;
		first_hash_d  = first_hash_q;
		hand_ok_d     = hand_ok_q;
		hand_bit_d    = hand_bit_q;
		fing_ok_d     = fing_ok_q;
		fing_bit_d    = fing_bit_q;
		finger_d      = finger_q;
		rate_d        = rate_q;
		flag_frame_d  = flag_frame_q;
		flag_resync_d = flag_resync_q;

		if (do_finish) begin
			if (field_cnt_q == FLD_SYNC) begin
				if (tok_len_q == 2'd1 && first_hash_q) begin
					if (synced_q)
						flag_resync_d = 1'b1;
					synced_d = 1'b1;
				end
			end else if (synced_q && field_cnt_q <= FLD_RATE_Z) begin
				case (field_cnt_q)
					FLD_HAND: begin
						hand_ok_d  = int_ok;
						hand_bit_d = int_bit;
					end
					FLD_FINGER_A, FLD_FINGER_B: begin
						fing_ok_d  = int_ok;
						fing_bit_d = int_bit;
					end
					FLD_PRESS_A, FLD_PRESS_B: begin
						if (hand_ok_q && fing_ok_q && int_ok)
							finger_d[{hand_bit_q, fing_bit_q}] = int_bit;
					end
					FLD_RATE_X: rate_d[0] = rate_val;
					FLD_RATE_Y: rate_d[1] = rate_val;
					FLD_RATE_Z: begin
						rate_d[2]    = rate_val;
						synced_d     = 1'b0;
						flag_frame_d = 1'b1;
					end
					default: ;
				endcase
			end
			if (field_cnt_q != FLD_MAX)
				field_cnt_d = field_cnt_q + 4'd1;
		end

		// drop token state after it is applied or at line end
		if (do_finish || res_fire) begin
			in_token_d   = 1'b0;
			tok_mag_d    = '0;
			tok_neg_d    = 1'b0;
			phase_d      = PH_WS;
			frac_cnt_d   = '0;
			tok_len_d    = '0;
			first_hash_d = 1'b0;
		end

		if (acc && !is_nul && !is_nl && keep)
			line_len_d = line_len_q + 6'd1;

		if (do_char) begin
			if (!in_token_q) begin
				in_token_d   = 1'b1;
				first_hash_d = (rx_byte == CH_HASH);
			end
			if (tok_len_q != 2'd2)
				tok_len_d = tok_len_q + 2'd1;
			case (phase_q)
				PH_WS, PH_SIGN, PH_INT: begin
					if (phase_q == PH_WS && is_ws) begin
						phase_d = PH_WS;
					end else if (phase_q == PH_WS && is_sign) begin
						tok_neg_d = (rx_byte == CH_MINUS);
						phase_d   = PH_SIGN;
					end else if (is_dig) begin
						tok_mag_d = (mag_ext > {4'd0, MAG_CAP}) ? MAG_CAP : mag_ext[31:0];
						phase_d   = PH_INT;
					end else if (is_dot) begin
						phase_d = PH_FRAC;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_FRAC: begin
					if (is_dig) begin
						if (frac_cnt_q < FD_MAX) begin
							tok_mag_d  = (mag_ext > {4'd0, MAG_CAP}) ? MAG_CAP
								: mag_ext[31:0];
							frac_cnt_d = frac_cnt_q + 2'd1;
						end
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		if (res_fire) begin
			field_cnt_d   = '0;
			line_len_d    = '0;
			flag_frame_d  = 1'b0;
			flag_resync_d = 1'b0;
		end
	end

	// report uses the state after the last token of the line is applied
	always_comb begin
		res.left_index     = finger_d[0];
		res.left_middle    = finger_d[1];
		res.right_index    = finger_d[2];
		res.right_middle   = finger_d[3];
		res.rate_x         = rate_d[0];
		res.rate_y         = rate_d[1];
		res.rate_z         = rate_d[2];
		res.gesture_mode   = gsfp_gesture(finger_d);
		res.frame_complete = flag_frame_q || (do_finish && synced_q
			&& field_cnt_q == FLD_RATE_Z);
		res.resync_seen    = flag_resync_q || (do_finish && synced_q
			&& field_cnt_q == FLD_SYNC && tok_len_q == 2'd1 && first_hash_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_cnt_q   <= '0;
			line_len_q    <= '0;
			in_token_q    <= 1'b0;
			synced_q      <= 1'b0;
			tok_mag_q     <= '0;
			tok_neg_q     <= 1'b0;
			phase_q       <= PH_WS;
			frac_cnt_q    <= '0;
			tok_len_q     <= '0;
			first_hash_q  <= 1'b0;
			hand_ok_q     <= 1'b1;
			hand_bit_q    <= 1'b0;
			fing_ok_q     <= 1'b1;
			fing_bit_q    <= 1'b0;
			finger_q      <= '0;
			rate_q        <= '{default: '0};
			flag_frame_q  <= 1'b0;
			flag_resync_q <= 1'b0;
		end else if (acc) begin
			field_cnt_q   <= field_cnt_d;
			line_len_q    <= line_len_d;
			in_token_q    <= in_token_d;
			synced_q      <= synced_d;
			tok_mag_q     <= tok_mag_d;
			tok_neg_q     <= tok_neg_d;
			phase_q       <= phase_d;
			frac_cnt_q    <= frac_cnt_d;
			tok_len_q     <= tok_len_d;
			first_hash_q  <= first_hash_d;
			hand_ok_q     <= hand_ok_d;
			hand_bit_q    <= hand_bit_d;
			fing_ok_q     <= fing_ok_d;
			fing_bit_q    <= fing_bit_d;
			finger_q      <= finger_d;
			rate_q        <= rate_d;
			flag_frame_q  <= flag_frame_d;
			flag_resync_q <= flag_resync_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_ready) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_fire;
				end
			end else if (res_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (res_fire)
				out_q <= res;
		end else if (res_fire) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_index     = out_q.left_index;
	assign left_middle    = out_q.left_middle;
	assign right_index    = out_q.right_index;
	assign right_middle   = out_q.right_middle;
	assign rate_x         = $signed(out_q.rate_x);
	assign rate_y         = $signed(out_q.rate_y);
	assign rate_z         = $signed(out_q.rate_z);
	assign gesture_mode   = out_q.gesture_mode;
	assign frame_complete = out_q.frame_complete;
	assign resync_seen    = out_q.resync_seen;

	`GSFP_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`GSFP_ASSERT_NOW(a_line_len_cap, clk, arst_n, 1'b1, line_len_q <= KEEP_LEN)
	`GSFP_ASSERT_NEXT(a_no_report_mid_line, clk, arst_n, acc && !is_nl && !out_valid_q, !out_valid_q)
	`GSFP_ASSERT_NEXT(a_nl_clears_line, clk, arst_n, res_fire, field_cnt_q == FLD_SYNC && line_len_q == 6'd0 && !in_token_q)
	`GSFP_ASSERT_NEXT(a_frame_drops_sync, clk, arst_n, res_fire && res.frame_complete, !synced_q)

endmodule

>>> tb/tb_glove_sensor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glove_sensor_frame_parser
// Feeds glove link bytes into the frame parser and checks every line report
// against a cycle-free model of the parser kept in the bench. Directed lines
// cover sync, resync, token forms, saturation and long lines; random frames
// and noise follow under several idle/stall mixes and one long output hold.
// ----------------------------------------------------------------------------
module tb_glove_sensor_frame_parser;

	import gsfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               left_index;
	logic               left_middle;
	logic               right_index;
	logic               right_middle;
	logic signed [23:0] rate_x;
	logic signed [23:0] rate_y;
	logic signed [23:0] rate_z;
	logic [2:0]         gesture_mode;
	logic               frame_complete;
	logic               resync_seen;

	glove_sensor_frame_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_index    (left_index),
		.left_middle   (left_middle),
		.right_index   (right_index),
		.right_middle  (right_middle),
		.rate_x        (rate_x),
		.rate_y        (rate_y),
		.rate_z        (rate_z),
		.gesture_mode  (gesture_mode),
		.frame_complete(frame_complete),
		.resync_seen   (resync_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	logic [3:0]  fld;
	logic        in_tok;
	logic        sync_held;
	logic [31:0] mag;
	logic        neg;
	gsfp_phase_t phase;
	logic [1:0]  frac_n;
	logic [5:0]  tok_len;
	logic [7:0]  tok_first;
	logic [5:0]  line_len;
	logic [31:0] hand_sel;
	logic [31:0] finger_sel;
	logic [3:0]  pressed;
	logic [23:0] rate_held [3];
	logic        got_frame;
	logic        got_resync;

	gsfp_result_t reports_due[$];

	int errors = 0;
	int bytes_sent = 0;
	int reports_seen = 0;
	int frames_seen = 0;
	int resyncs_seen = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	logic hold_off = 1'b0;

	task automatic clear_token();
		in_tok = 1'b0;
		mag = '0;
		neg = 1'b0;
		phase = PH_WS;
		frac_n = '0;
		tok_len = '0;
		tok_first = '0;
	endtask

	task automatic reset_parser_model();
		fld = '0;
		sync_held = 1'b0;
		line_len = '0;
		got_frame = 1'b0;
		got_resync = 1'b0;
		hand_sel = '0;
		finger_sel = '0;
		pressed = '0;
		for (int i = 0; i < 3; i++)
			rate_held[i] = '0;
		clear_token();
	endtask

	task automatic add_digit(input logic [7:0] d);
		logic [63:0] m;
		m = {32'd0, mag} * 10 + d;
		mag = (m > MAG_CAP) ? MAG_CAP : m[31:0];
	endtask

	function automatic logic [31:0] tok_int();
		if (neg)
			return 32'd0 - mag;
		return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
	endfunction

	function automatic logic [23:0] tok_rate();
		logic [63:0] v;
		v = {32'd0, mag};
		for (int k = frac_n; k < FRAC_DIGITS_DEF; k++)
			v = v * 10;
		if (neg) begin
			if (v > RATE_MIN_MAG)
				v = RATE_MIN_MAG;
			v = 64'd0 - v;
			return v[23:0];
		end
		if (v > RATE_MAX)
			v = RATE_MAX;
		return v[23:0];
	endfunction

	// apply the finished token to the field it lands on
	task automatic close_token();
		logic [31:0] v;
		if (!in_tok)
			return;
		if (fld == FLD_SYNC) begin
			if (tok_len == 6'd1 && tok_first == CH_HASH) begin
				if (sync_held)
					got_resync = 1'b1;
				sync_held = 1'b1;
			end
		end else if (sync_held && fld <= FLD_RATE_Z) begin
			case (fld)
				FLD_HAND: hand_sel = tok_int();
				FLD_FINGER_A, FLD_FINGER_B: finger_sel = tok_int();
				FLD_PRESS_A, FLD_PRESS_B: begin
					v = tok_int();
					if (hand_sel <= 1 && finger_sel <= 1 && v <= 1)
						pressed[{hand_sel[0], finger_sel[0]}] = v[0];
				end
				FLD_RATE_X: rate_held[0] = tok_rate();
				FLD_RATE_Y: rate_held[1] = tok_rate();
				default: begin
					rate_held[2] = tok_rate();
					sync_held = 1'b0;
					got_frame = 1'b1;
				end
			endcase
		end
		if (fld < FLD_MAX)
			fld++;
		clear_token();
	endtask

	task automatic advance_parser(input logic [7:0] c);
		gsfp_result_t r;
		logic dig;
		logic dot;
		if (c == CH_NUL)
			return;
		if (c == CH_NL) begin
			close_token();
			r.left_index = pressed[0];
			r.left_middle = pressed[1];
			r.right_index = pressed[2];
			r.right_middle = pressed[3];
			r.rate_x = rate_held[0];
			r.rate_y = rate_held[1];
			r.rate_z = rate_held[2];
			case (pressed)
				4'h0:       r.gesture_mode = GEST_NOTHING;
				4'h2, 4'h8: r.gesture_mode = GEST_ZOOM;
				4'h1, 4'h4: r.gesture_mode = GEST_PICK;
				4'h3, 4'hC: r.gesture_mode = GEST_SPIN;
				default:    r.gesture_mode = GEST_UNDETECTED;
			endcase
			r.frame_complete = got_frame;
			r.resync_seen = got_resync;
			reports_due.push_back(r);
			fld = '0;
			line_len = '0;
			got_frame = 1'b0;
			got_resync = 1'b0;
			clear_token();
			return;
		end
		// drop the tail of an overlong line
		if (line_len >= LINE_KEEP_DEF)
			return;
		line_len++;
		if (c == CH_SEMI) begin
			close_token();
			return;
		end
		if (!in_tok) begin
			in_tok = 1'b1;
			tok_first = c;
		end
		if (tok_len < 6'd63)
			tok_len++;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		dot = (c == CH_DOT) && (fld >= FLD_RATE_X) && (fld <= FLD_RATE_Z);
		if (phase == PH_WS && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
			return;
		if (phase == PH_WS && (c == CH_PLUS || c == CH_MINUS)) begin
			neg = (c == CH_MINUS);
			phase = PH_SIGN;
			return;
		end
		case (phase)
			PH_WS, PH_SIGN, PH_INT: begin
				if (dig) begin
					add_digit(c - CH_ZERO);
					phase = PH_INT;
				end else if (dot) begin
					phase = PH_FRAC;
				end else begin
					phase = PH_DONE;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					if (frac_n < FRAC_DIGITS_DEF) begin
						add_digit(c - CH_ZERO);
						frac_n++;
					end
				end else begin
					phase = PH_DONE;
				end
			end
			default: ;
		endcase
	endtask

	// offer one byte; valid stays up until it is taken
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		advance_parser(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic cmp_field(input string name, input logic [23:0] want, input logic [23:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_report();
		gsfp_result_t want;
		if (reports_due.size() == 0) begin
			errors++;
			$display("%0t: report with no line pending, expected none, actual rate_x %0h",
				$time, rate_x);
			return;
		end
		want = reports_due.pop_front();
		reports_seen++;
		frames_seen += want.frame_complete;
		resyncs_seen += want.resync_seen;
		cmp_field("left_index", want.left_index, left_index);
		cmp_field("left_middle", want.left_middle, left_middle);
		cmp_field("right_index", want.right_index, right_index);
		cmp_field("right_middle", want.right_middle, right_middle);
		cmp_field("rate_x", want.rate_x, rate_x);
		cmp_field("rate_y", want.rate_y, rate_y);
		cmp_field("rate_z", want.rate_z, rate_z);
		cmp_field("gesture_mode", want.gesture_mode, gesture_mode);
		cmp_field("frame_complete", want.frame_complete, frame_complete);
		cmp_field("resync_seen", want.resync_seen, resync_seen);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_report();
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// long output hold on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		end
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_glove_sensor_frame_parser NOT OK");
		$finish;
	end

	function automatic string sel_text();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 8)
			return "0";
		if (pick < 16)
			return "1";
		if (pick == 16)
			return "2";
		if (pick == 17)
			return "-1";
		if (pick == 18)
			return " +1";
		return $sformatf("%0d", $urandom);
	endfunction

	function automatic string rate_text();
		string s;
		int pick;
		s = "";
		pick = $urandom_range(0, 9);
		if (pick < 3)
			s = "-";
		else if (pick == 3)
			s = "+";
		else if (pick == 4)
			s = " ";
		pick = $urandom_range(0, 9);
		if (pick == 0)
			s = {s, $sformatf("%0d", $urandom_range(8000, 99999999))};
		else if (pick < 8)
			s = {s, $sformatf("%0d", $urandom_range(0, 999))};
		if ($urandom_range(0, 2) != 0) begin
			s = {s, "."};
			pick = $urandom_range(0, 3);
			if (pick == 1)
				s = {s, $sformatf("%0d", $urandom_range(0, 9))};
			else if (pick == 2)
				s = {s, $sformatf("%03d", $urandom_range(0, 999))};
			else if (pick == 3)
				s = {s, $sformatf("%0d", $urandom_range(0, 99999))};
		end
		if ($urandom_range(0, 15) == 0)
			s = {s, "e2"};
		return s;
	endfunction

	function automatic string frame_text();
		string s;
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			s = "";
		else if (pick == 1)
			s = " #";
		else
			s = "#";
		s = {s, ";", sel_text(), ";", sel_text(), ";", sel_text(), ";", sel_text(),
			";", sel_text(), ";", rate_text(), ";", rate_text(), ";", rate_text()};
		return s;
	endfunction

	task automatic send_random_line();
		string s;
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_text({frame_text(), "\n"});
		end else if (pick < 80) begin
			// cut frame, can leave sync hanging
			s = frame_text();
			send_text({s.substr(0, $urandom_range(0, s.len() - 1)), "\n"});
		end else if (pick < 90) begin
			n = $urandom_range(1, 24);
			repeat (n) push_byte(8'($urandom_range(0, 255)));
			push_byte(CH_NL);
		end else if (pick < 95) begin
			send_text({frame_text(), ";", sel_text(), ";;", rate_text(), "\n"});
		end else begin
			send_text("\n");
		end
	endtask

	task automatic test_basic_frames();
		send_text("\n");
		send_text("#;0;0;1;1;1;1.5;-2.25;3\n");
		send_text("#;1;0;1;1;0;-0.001;+8388.607;9000\n");
		send_text("#;1;0;0;0;0;-9000;0.0009;-8388.608\n");
	endtask

	task automatic test_resync();
		send_text("#;1\n");
		send_text("#;1;1;1;0;1\n");
		// not an exact sync token, sync carries over
		send_text("##;0;1;0\n");
		send_text("#;0;0;0;1;0;1;2;3\n");
	endtask

	task automatic test_token_forms();
		send_text(";;#;;\t+1;;0;;1.9;1;-0;1e3;7.123456;-.5\n");
		send_text("#;0");
		push_byte(CH_NUL);
		send_text(";1;1;-;+-3; 12.;.\n");
	endtask

	task automatic test_saturation();
		send_text("#;99999999999;0;1\n");
		send_text("#;-1;0;1;0;-1;-99999999999;99999999999;0\n");
	endtask

	task automatic test_long_lines();
		send_text({"#;1;1;1;0;1;12;34;", {30{"5"}}, ";6\n"});
		send_text("#;0;0;0;0;0;0;0;0;a;b;c;d;e;f;g;h;i\n");
	endtask

	task automatic test_output_hold();
		send_idle_pct = 0;
		stall_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (30) send_text("\n");
		repeat (4) send_text("#;0;1;1;2\n");
	endtask

	task automatic test_random(input int idle_pct, input int stall, input int n_bytes);
		int target;
		send_idle_pct = idle_pct;
		stall_pct <= stall;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target)
			send_random_line();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		reset_parser_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frames();
		test_resync();
		test_token_forms();
		test_saturation();
		test_long_lines();
		test_output_hold();
		test_random(0, 0, 165);
		test_random(64, 0, 165);
		test_random(0, 64, 165);
		test_random(28, 28, 165);

		in_valid <= 1'b0;
		stall_pct <= 0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d reports (%0d full frames, %0d resyncs)",
			bytes_sent, reports_seen, frames_seen, resyncs_seen);
		$display("Mixes: none, sender 64%%, receiver 64%%, both 28%%, one long hold");
		if (errors == 0) begin
			$display("tb_glove_sensor_frame_parser OK");
		end else begin
			$display("tb_glove_sensor_frame_parser NOT OK");
		end
		$finish;
	end

endmodule
